// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by utf8d_decode and utf8_stream_decoder_unit.
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  // Lead byte thresholds
  localparam logic [BYTE_W-1:0] LEAD_1B_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_2B_LIMIT = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_3B_LIMIT = 8'hF0;

  // Payload masks
  localparam logic [BYTE_W-1:0] LEAD_2B_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD_3B_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD_4B_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;

  // Continuation counts left after a lead byte
  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  // Result of decoding one item
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] value;
  } dec_result_t;

endpackage

// ===== hw/rtl/utf8d_decode.sv =====
// Decode step: sequence state registers and the per-byte decode logic.
// Depends on utf8d_pkg.
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] byte_cur,
  output dec_result_t       result
);

  logic [PEND_W-1:0] bytes_pending, bytes_pending_next;
  logic [CP_W-1:0]   partial_value, partial_value_next;
  logic [CP_W-1:0]   shifted;

  // Continuation: shift in the low 6 bits of the byte
  assign shifted = {partial_value[CP_W-7:0], byte_cur[5:0] & CONT_MASK[5:0]};

  // Lead or continuation decode
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    result.emit        = 1'b0;
    result.value       = shifted;
    if (bytes_pending == PEND_NONE) begin
      priority if (byte_cur < LEAD_1B_LIMIT) begin
        result.emit  = 1'b1;
        result.value = {{(CP_W-BYTE_W){1'b0}}, byte_cur};
      end else if (byte_cur < LEAD_2B_LIMIT) begin
        partial_value_next = {{(CP_W-BYTE_W){1'b0}}, byte_cur & LEAD_2B_MASK};
        bytes_pending_next = PEND_ONE;
      end else if (byte_cur < LEAD_3B_LIMIT) begin
        partial_value_next = {{(CP_W-BYTE_W){1'b0}}, byte_cur & LEAD_3B_MASK};
        bytes_pending_next = PEND_TWO;
      end else begin
        partial_value_next = {{(CP_W-BYTE_W){1'b0}}, byte_cur & LEAD_4B_MASK};
        bytes_pending_next = PEND_THREE;
      end
    end else begin
      bytes_pending_next = bytes_pending - PEND_ONE;
      if (bytes_pending == PEND_ONE) begin
        result.emit        = 1'b1;
        partial_value_next = '0;
      end else begin
        partial_value_next = shifted;
      end
    end
  end

  // State update, only when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      partial_value <= '0;
    end else if (advance) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// Top level of the UTF-8 stream decoder: input register, decode, result register.
// Depends on utf8d_pkg and utf8d_decode.
//
// channel   dir  handshake              payload
// byte      in   byte_valid/byte_stall  byte_in    [7:0]
// cp        out  cp_valid/cp_stall      code_point [20:0]
//
// One byte is accepted per cycle while byte_stall is low; cp_valid rises once the byte that
// completes a sequence has moved from the input register through decode into the result register.
// A single decode stage sits between the two registers.
// rst is synchronous and clears both valid flags and the sequence state.
// A stall on cp holds the result; byte_stall rises only when the input register
// is full and cannot move on.
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [BYTE_W-1:0] byte_in,
  output logic              cp_valid,
  input  logic              cp_stall,
  output logic [CP_W-1:0]   code_point
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic              accept;
  dec_result_t       result;

  // Flow control
  assign advance    = s1_valid && (!cp_valid || !cp_stall);
  assign byte_stall = s1_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= byte_in;
    end
  end

  utf8d_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .byte_cur (s1_byte),
    .result   (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (advance) begin
      cp_valid <= result.emit;
    end else if (!cp_stall) begin
      cp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      code_point <= result.value;
    end
  end

`ifndef SYNTHESIS
  // A completed item shows up on the output next cycle
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && result.emit |=> cp_valid)
    else $error("decoded item did not reach the result register");

  // Never stall an empty input register
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid)
    else $error("byte_stall with empty input register");

  // A result is never overwritten while the consumer stalls it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && result.emit |-> !(cp_valid && cp_stall))
    else $error("held result overwritten");
`endif

endmodule

// ===== dv/utf8_stream_decoder_unit_tb.sv =====
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte streams.
// Decoded code points are predicted in the bench and checked in order.
// Depends on utf8d_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1525;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    logic              hold;   // pause sender until all code points are back
    logic [BYTE_W-1:0] data;
  } byte_slot_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              byte_valid = 1'b0;
  logic [BYTE_W-1:0] byte_in    = '0;
  logic              cp_stall   = 1'b0;
  logic              byte_stall;
  logic              cp_valid;
  logic [CP_W-1:0]   code_point;

  byte_slot_t        byte_slots[$];
  logic [CP_W-1:0]   cp_expect[$];

  // Bench copy of the sequence state
  logic [PEND_W-1:0] seq_left = PEND_NONE;
  logic [CP_W-1:0]   seq_acc  = '0;

  logic              tail_phase = 1'b0;
  int unsigned       send_gap, send_quiet, stall_left, stall_quiet;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;

  utf8_stream_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_in   (byte_in),
    .cp_valid  (cp_valid),
    .cp_stall  (cp_stall),
    .code_point(code_point)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Advance the decoder state by one byte; emit marks a finished code point
  task automatic decode_step(input logic [BYTE_W-1:0] b, output logic emit,
                             output logic [CP_W-1:0] cp);
    emit = 1'b0;
    cp   = '0;
    if (seq_left == PEND_NONE) begin
      if (b < LEAD_1B_LIMIT) begin
        emit = 1'b1;
        cp   = CP_W'(b);
      end else if (b < LEAD_2B_LIMIT) begin
        seq_acc  = CP_W'(b & LEAD_2B_MASK);
        seq_left = PEND_ONE;
      end else if (b < LEAD_3B_LIMIT) begin
        seq_acc  = CP_W'(b & LEAD_3B_MASK);
        seq_left = PEND_TWO;
      end else begin
        seq_acc  = CP_W'(b & LEAD_4B_MASK);
        seq_left = PEND_THREE;
      end
    end else begin
      // continuation: top two bits ignored
      seq_acc  = (seq_acc << 6) | CP_W'(b & CONT_MASK);
      seq_left = seq_left - 1'b1;
      if (seq_left == PEND_NONE) begin
        emit    = 1'b1;
        cp      = seq_acc;
        seq_acc = '0;
      end
    end
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    byte_slot_t slot;
    slot.hold = 1'b0;
    slot.data = b;
    byte_slots.insert(byte_slots.size(), slot);
  endtask

  task automatic queue_hold();
    byte_slot_t slot;
    slot.hold = 1'b1;
    slot.data = '0;
    byte_slots.insert(byte_slots.size(), slot);
  endtask

  // Random stream: mostly well-formed sequences, some noise bytes
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_byte(8'($urandom_range(0, 255)));
        n++;
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1: queue_byte(8'($urandom_range(8'h00, 8'h7F)));
          2: queue_byte(8'($urandom_range(8'hC0, 8'hDF)));
          3: queue_byte(8'($urandom_range(8'hE0, 8'hEF)));
          default: queue_byte(8'($urandom_range(8'hF0, 8'hFF)));
        endcase
        repeat (len - 1) queue_byte(8'h80 | 8'($urandom_range(0, 63)));
        n += len;
      end
      if (n >= count / 2 && n < count / 2 + 4) queue_hold();
    end
  endtask

  // Byte sender: presents the queued items, holds payload while stalled
  always @(posedge clk) begin : byte_driver
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_byte;
    logic              emit;
    logic [CP_W-1:0]   cp;
    nxt_valid = byte_valid;
    nxt_byte  = byte_in;
    if (rst) begin
      nxt_valid   = 1'b0;
      seq_left    = PEND_NONE;
      seq_acc     = '0;
      send_gap    = 0;
      send_quiet  = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_step(byte_in, emit, cp);
        if (emit) cp_expect.insert(cp_expect.size(), cp);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && byte_slots.size() != 0) begin
        if (byte_slots[0].hold) begin
          if (cp_expect.size() == 0 && !cp_valid) void'(byte_slots.pop_front());
        end else if (send_gap != 0) begin
          send_gap--;
        end else begin
          nxt_byte  = byte_slots[0].data;
          nxt_valid = 1'b1;
          void'(byte_slots.pop_front());
          // idle bursts, with quiet stretches mixed in
          if (tail_phase) send_gap = 0;
          else if (send_quiet != 0) send_quiet--;
          else if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(20, 60);
          else if ($urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 9);
        end
      end
    end
    byte_valid <= nxt_valid;
    byte_in    <= nxt_byte;
    tail_phase <= (byte_slots.size() < TAIL_ITEMS);
  end

  // Code point receiver: checks each item and stalls in random bursts
  always @(posedge clk) begin : cp_monitor
    logic            nxt_stall;
    logic [CP_W-1:0] want;
    nxt_stall = 1'b0;
    if (rst) begin
      stall_left  = 0;
      stall_quiet = 0;
    end else begin
      if (cp_valid === 1'b1 && !cp_stall) begin
        if (cp_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected code point 0x%06h", code_point));
        end else begin
          want = cp_expect.pop_front();
          if (code_point !== want)
            report_mismatch($sformatf("code_point 0x%06h, want 0x%06h", code_point, want));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!tail_phase) begin
        if (stall_quiet != 0) begin
          stall_quiet--;
        end else if ($urandom_range(0, 29) == 0) begin
          stall_quiet = $urandom_range(20, 60);
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 9) - 1;
          nxt_stall  = 1'b1;
        end
      end
    end
    cp_stall <= nxt_stall;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Directed: ASCII extremes, stray continuation as lead, each length at its
    // extremes, a surrogate, 0xF8..0xFF leads, lead-looking continuations
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'h80); queue_byte(8'hBF);
    queue_byte(8'hDF); queue_byte(8'hFF);
    queue_byte(8'hE0); queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'hED); queue_byte(8'hA0); queue_byte(8'h80);
    queue_byte(8'hF0); queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'h80);
    queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'hFF);
    queue_byte(8'hF8); queue_byte(8'hC3); queue_byte(8'h7F); queue_byte(8'h3F);
    queue_hold();
    queue_random(RANDOM_ITEMS);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (byte_slots.size() != 0 || byte_valid || cp_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
